FILE: rtl/por_pkg.sv
// shared types and constants for the polar order parameter unit
package por_pkg;

  localparam int MaxParticles = 4096;
  localparam int CntW         = $clog2(MaxParticles + 1);
  localparam int OneQ14       = 16384;

  localparam int VelW   = 16;
  localparam int SqW    = 31;
  localparam int MW     = 32;
  localparam int FracSh = 28;
  localparam int RadW   = MW + FracSh;
  localparam int RootW  = RadW / 2;
  localparam int SumW   = 28;
  localparam int DivAW  = VelW + FracSh;
  localparam int DivBW  = RootW;
  localparam int NormSteps = 15;
  localparam int MeanSteps = SumW - 1;
  localparam int QW     = MeanSteps;
  localparam int StepW  = $clog2(MeanSteps + 1);
  localparam int SqrtTopNorm = RadW - 2;
  localparam int SqrtTopMag  = 28;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQUARE, ST_NORM, ST_SQRT, ST_DIVX, ST_DIVY, ST_CHECK,
    ST_MDIVX, ST_MDIVY, ST_MSQUARE, ST_MSQRT, ST_MWAIT, ST_EMIT
  } state_t;

  typedef enum logic [1:0] {DIV_NX, DIV_NY, DIV_MX, DIV_MY} div_op_t;

  typedef struct packed {
    logic    in_load;
    logic    sq_load;
    logic    sq_mean;
    logic    cnt_inc;
    logic    sqrt_start;
    logic    sqrt_mag;
    logic    div_start;
    div_op_t div_op;
    logic    sum_x_add;
    logic    sum_y_add;
    logic    mean_x_load;
    logic    mean_y_load;
    logic    out_load;
  } por_cmd_t;

  typedef struct packed {
    logic last;
    logic cnt_full;
    logic m_zero;
    logic sqrt_done;
    logic div_done;
    logic out_busy;
  } por_stat_t;

endpackage

FILE: rtl/por_sqrt.sv
// iterative integer square root, one result bit per cycle
module por_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      mag,
  input  logic [por_pkg::RadW-1:0]  op,
  output logic                      done,
  output logic [por_pkg::RootW-1:0] root
);
  import por_pkg::*;

  logic [RadW-1:0] v;
  logic [RadW-1:0] r;
  logic [RadW-1:0] bitr;
  logic            busy;
  logic [RadW-1:0] trial;
  logic            ge;

  assign trial = r + bitr;
  assign ge    = (v >= trial);
  assign root  = r[RootW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitr[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= op;
      r    <= '0;
      bitr <= mag ? (RadW'(1) << SqrtTopMag) : (RadW'(1) << SqrtTopNorm);
    end else if (busy) begin
      if (ge) begin
        v <= v - trial;
        r <= (r >> 1) + bitr;
      end else begin
        r <= r >> 1;
      end
      bitr <= bitr >> 2;
    end
  end

endmodule

FILE: rtl/por_div.sv
// restoring divider with a short or long step count, one quotient bit per cycle
module por_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      mean,
  input  logic [por_pkg::DivAW-1:0] a,
  input  logic [por_pkg::DivBW-1:0] b,
  output logic                      done,
  output logic [por_pkg::QW-1:0]    quo
);
  import por_pkg::*;

  logic [DivBW:0]   rem;
  logic [QW-1:0]    shf;
  logic [DivBW-1:0] b_r;
  logic [StepW-1:0] cnt;
  logic             busy;
  logic [DivBW:0]   trial;
  logic             ge;

  assign trial = {rem[DivBW-1:0], shf[QW-1]};
  assign ge    = (trial >= {1'b0, b_r});
  assign quo   = shf;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == StepW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      b_r <= b;
      if (mean) begin
        rem <= (DivBW+1)'(a[DivAW-1:MeanSteps]);
        shf <= a[MeanSteps-1:0];
        cnt <= StepW'(MeanSteps);
      end else begin
        // quotient fits in the short step count, top bits start below the divisor
        rem <= (DivBW+1)'(a[DivAW-1:NormSteps]);
        shf <= {a[NormSteps-1:0], (QW-NormSteps)'(0)};
        cnt <= StepW'(NormSteps);
      end
    end else if (busy) begin
      rem <= ge ? (trial - {1'b0, b_r}) : trial;
      shf <= {shf[QW-2:0], ge};
      cnt <= cnt - StepW'(1);
    end
  end

endmodule

FILE: rtl/por_dp.sv
// datapath: squares, shared root and divide units, sums, count, output register
module por_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [15:0]            vel_x,
  input  logic signed [15:0]            vel_y,
  input  logic                          last,
  input  por_pkg::por_cmd_t             cmd,
  output por_pkg::por_stat_t            stat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            mean_x,
  output logic signed [15:0]            mean_y,
  output logic [14:0]                   magnitude
);
  import por_pkg::*;

  logic signed [VelW-1:0] vx, vy;
  logic                   last_r;
  logic signed [VelW-1:0] mx, my;
  logic signed [VelW-1:0] mul_a, mul_b;
  logic signed [MW-1:0]   prod_a, prod_b;
  logic [SqW-1:0]         sq_x, sq_y;
  logic [MW-1:0]          m;
  logic [RadW-1:0]        sqrt_op;
  logic                   sqrt_done;
  logic [RootW-1:0]       root;
  logic signed [SumW-1:0] sum_x, sum_y;
  logic [CntW-1:0]        count;
  logic [VelW-1:0]        vx_abs, vy_abs;
  logic [SumW-1:0]        sx_abs, sy_abs;
  logic [DivAW-1:0]       div_a;
  logic [DivBW-1:0]       div_b;
  logic                   div_mean;
  logic                   div_done;
  logic [QW-1:0]          quo;
  logic [SumW-1:0]        q_pos;
  logic [VelW-1:0]        q_low;
  logic                   out_valid_next;

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      vx     <= vel_x;
      vy     <= vel_y;
      last_r <= last;
    end
  end

  assign mul_a  = cmd.sq_mean ? mx : vx;
  assign mul_b  = cmd.sq_mean ? my : vy;
  assign prod_a = mul_a * mul_a;
  assign prod_b = mul_b * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.sq_load) begin
      sq_x <= prod_a[SqW-1:0];
      sq_y <= prod_b[SqW-1:0];
    end
  end

  assign m       = {1'b0, sq_x} + {1'b0, sq_y};
  assign sqrt_op = cmd.sqrt_mag ? {FracSh'(0), m} : {m, FracSh'(0)};

  por_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sqrt_start),
    .mag   (cmd.sqrt_mag),
    .op    (sqrt_op),
    .done  (sqrt_done),
    .root  (root)
  );

  assign vx_abs = vx[VelW-1] ? VelW'(-vx) : VelW'(vx);
  assign vy_abs = vy[VelW-1] ? VelW'(-vy) : VelW'(vy);
  assign sx_abs = sum_x[SumW-1] ? SumW'(-sum_x) : SumW'(sum_x);
  assign sy_abs = sum_y[SumW-1] ? SumW'(-sum_y) : SumW'(sum_y);

  always_comb begin
    div_a    = '0;
    div_b    = root;
    div_mean = 1'b0;
    case (cmd.div_op)
      DIV_NX: div_a = {vx_abs, FracSh'(0)};
      DIV_NY: div_a = {vy_abs, FracSh'(0)};
      DIV_MX: begin
        div_a    = DivAW'(sx_abs[QW-1:0]);
        div_b    = DivBW'(count);
        div_mean = 1'b1;
      end
      default: begin
        div_a    = DivAW'(sy_abs[QW-1:0]);
        div_b    = DivBW'(count);
        div_mean = 1'b1;
      end
    endcase
  end

  por_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .mean  (div_mean),
    .a     (div_a),
    .b     (div_b),
    .done  (div_done),
    .quo   (quo)
  );

  assign q_pos = {1'b0, quo};
  assign q_low = quo[VelW-1:0];

  always_ff @(posedge clk) begin
    if (rst || cmd.out_load) begin
      sum_x <= '0;
      sum_y <= '0;
      count <= '0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + CntW'(1);
      end
      if (cmd.sum_x_add) begin
        sum_x <= vx[VelW-1] ? (sum_x - $signed(q_pos)) : (sum_x + $signed(q_pos));
      end
      if (cmd.sum_y_add) begin
        sum_y <= vy[VelW-1] ? (sum_y - $signed(q_pos)) : (sum_y + $signed(q_pos));
      end
    end
  end

  // mean sign follows the sum, quotient is the truncated magnitude
  always_ff @(posedge clk) begin
    if (cmd.mean_x_load) begin
      mx <= sum_x[SumW-1] ? $signed(VelW'(-q_low)) : $signed(q_low);
    end
    if (cmd.mean_y_load) begin
      my <= sum_y[SumW-1] ? $signed(VelW'(-q_low)) : $signed(q_low);
    end
  end

  assign out_valid_next = cmd.out_load | (out_valid & out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mean_x    <= mx;
      mean_y    <= my;
      magnitude <= (root > RootW'(OneQ14)) ? 15'(OneQ14) : root[14:0];
    end
  end

  assign stat.last      = last_r;
  assign stat.cnt_full  = (count == CntW'(MaxParticles));
  assign stat.m_zero    = (m == '0);
  assign stat.sqrt_done = sqrt_done;
  assign stat.div_done  = div_done;
  assign stat.out_busy  = out_valid & out_stall;

endmodule

FILE: rtl/por_ctrl.sv
// controller: sequences squaring, normalization, accumulation and the final mean
module por_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output por_pkg::por_cmd_t   cmd,
  input  por_pkg::por_stat_t  stat
);
  import por_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_op = DIV_NX;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_next  = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.sq_load = 1'b1;
        state_next  = ST_NORM;
      end
      ST_NORM: begin
        // a full set ignores the particle, a zero vector only counts
        if (stat.cnt_full) begin
          state_next = ST_CHECK;
        end else begin
          cmd.cnt_inc = 1'b1;
          if (stat.m_zero) begin
            state_next = ST_CHECK;
          end else begin
            cmd.sqrt_start = 1'b1;
            state_next     = ST_SQRT;
          end
        end
      end
      ST_SQRT: begin
        if (stat.sqrt_done) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = DIV_NX;
          state_next    = ST_DIVX;
        end
      end
      ST_DIVX: begin
        if (stat.div_done) begin
          cmd.sum_x_add = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_op    = DIV_NY;
          state_next    = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (stat.div_done) begin
          cmd.sum_y_add = 1'b1;
          state_next    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.last) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = DIV_MX;
          state_next    = ST_MDIVX;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_MDIVX: begin
        cmd.div_op = DIV_MX;
        if (stat.div_done) begin
          cmd.mean_x_load = 1'b1;
          cmd.div_start   = 1'b1;
          cmd.div_op      = DIV_MY;
          state_next      = ST_MDIVY;
        end
      end
      ST_MDIVY: begin
        cmd.div_op = DIV_MY;
        if (stat.div_done) begin
          cmd.mean_y_load = 1'b1;
          state_next      = ST_MSQUARE;
        end
      end
      ST_MSQUARE: begin
        cmd.sq_load = 1'b1;
        cmd.sq_mean = 1'b1;
        state_next  = ST_MSQRT;
      end
      ST_MSQRT: begin
        cmd.sqrt_start = 1'b1;
        cmd.sqrt_mag   = 1'b1;
        state_next     = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (stat.sqrt_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // wait for the output register to free up before the transfer
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/polar_order_parameter_unit.sv
// Polar order parameter unit: one item per particle velocity, one result per set.
// Each nonzero velocity passes through the shared 30-step square root and the shared
// divider (15 steps per component); a zero or ignored velocity skips both, and no new
// velocity is taken until the last one is through. The item marked last then adds two
// 27-step mean divisions and a 15-step magnitude root before the result appears.
// Reset (synchronous, active high) clears the sums, the count and the output valid.
module polar_order_parameter_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] mean_x,
  output logic signed [15:0] mean_y,
  output logic [14:0]        magnitude
);
  import por_pkg::*;

  por_cmd_t  cmd;
  por_stat_t stat;

  por_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  por_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .last      (last),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .mean_x    (mean_x),
    .mean_y    (mean_y),
    .magnitude (magnitude)
  );

endmodule

FILE: rtl/por_check.sv
// port-level checks for the polar order parameter unit, bound to the top level
module por_check (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic signed [15:0] vel_x,
  input logic signed [15:0] vel_y,
  input logic               last,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] mean_x,
  input logic signed [15:0] mean_y,
  input logic [14:0]        magnitude
);

  // held result keeps its payload while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mean_x) && $stable(mean_y)
      && $stable(magnitude))
    else $error("result changed while stalled");

  a_mag_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> magnitude <= 15'd16384 && mean_x >= -16'sd16384
      && mean_x <= 16'sd16384 && mean_y >= -16'sd16384 && mean_y <= 16'sd16384)
    else $error("result out of range");

  // one item at a time: busy right after an input transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  a_emit_ends_item: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall) && !in_stall)
    else $error("result not at end of an item");

endmodule

bind polar_order_parameter_unit por_check u_por_check (.*);

FILE: sim/polar_order_checker.sv
`timescale 1ns / 1ps
// checker for the polar order parameter unit: predicts each set's mean vector and compares results
module polar_order_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic               last,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] mean_x,
  input  logic signed [15:0] mean_y,
  input  logic [14:0]        magnitude,
  output int                 mismatches,
  output int                 sets_due,
  output int                 sets_checked
);
  import por_pkg::*;

  localparam longint UnitScale = longint'(1) << FracSh;

  typedef struct packed {
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic [14:0]        mag;
  } mean_vector_t;

  mean_vector_t expected_means[$];
  longint       dir_sum_x;
  longint       dir_sum_y;
  int           members;

  function automatic longint unsigned int_sqrt(input longint unsigned radicand);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    rem   = radicand;
    root  = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    mean_vector_t    want;
    longint          sq;
    longint          len;
    longint          mx;
    longint          my;
    longint unsigned mag;
    if (rst) begin
      expected_means.delete();
      dir_sum_x    = 0;
      dir_sum_y    = 0;
      members      = 0;
      mismatches   = 0;
      sets_checked = 0;
      sets_due    <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        // particles past the limit neither count nor add
        if (members < MaxParticles) begin
          members++;
          sq = longint'(vel_x) * vel_x + longint'(vel_y) * vel_y;
          if (sq != 0) begin
            len = longint'(int_sqrt(unsigned'(sq) << FracSh));
            dir_sum_x += (longint'(vel_x) * UnitScale) / len;
            dir_sum_y += (longint'(vel_y) * UnitScale) / len;
          end
        end
        if (last) begin
          mx  = dir_sum_x / longint'(members);
          my  = dir_sum_y / longint'(members);
          mag = int_sqrt(unsigned'(mx * mx + my * my));
          if (mag > OneQ14) mag = OneQ14;
          want.mx  = mx[15:0];
          want.my  = my[15:0];
          want.mag = mag[14:0];
          expected_means = {expected_means, want};
          dir_sum_x = 0;
          dir_sum_y = 0;
          members   = 0;
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_means.size() == 0) begin
          report_mismatch("result transfer with no set pending");
        end else begin
          want = expected_means.pop_front();
          if (mean_x !== want.mx)
            report_mismatch($sformatf("mean_x got %0d expected %0d", mean_x, want.mx));
          if (mean_y !== want.my)
            report_mismatch($sformatf("mean_y got %0d expected %0d", mean_y, want.my));
          if (magnitude !== want.mag)
            report_mismatch($sformatf("magnitude got %0d expected %0d", magnitude, want.mag));
          sets_checked++;
        end
      end
      sets_due <= expected_means.size();
    end
  end

endmodule

FILE: sim/polar_order_parameter_unit_tb.sv
`timescale 1ns / 1ps
// testbench top for the polar order parameter unit: stimulus, stall patterns and verdict
module polar_order_parameter_unit_tb;
  import por_pkg::*;

  typedef enum logic [1:0] {TRAFFIC_RANDOM, TRAFFIC_STEADY, TRAFFIC_BACKLOG} traffic_t;

  localparam int HoldCycles    = 3000;
  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 300;
  localparam int RandomItems   = 1050;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic               last;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] mean_x;
  logic signed [15:0] mean_y;
  logic [14:0]        magnitude;

  traffic_t traffic;
  int       hold_left = 0;
  logic     hold_done = 1'b0;
  int       quiet_cycles = 0;
  int       mismatches;
  int       sets_due;
  int       sets_checked;
  int       transfers_sent = 0;

  polar_order_parameter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .mean_x    (mean_x),
    .mean_y    (mean_y),
    .magnitude (magnitude)
  );

  polar_order_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .vel_x        (vel_x),
    .vel_y        (vel_y),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mean_x       (mean_x),
    .mean_y       (mean_y),
    .magnitude    (magnitude),
    .mismatches   (mismatches),
    .sets_due     (sets_due),
    .sets_checked (sets_checked)
  );

  always #1 clk = ~clk;

  // result side: random stalls, one long hold to back up the unit
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (traffic == TRAFFIC_BACKLOG && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (traffic == TRAFFIC_STEADY) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 33);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_velocity(input logic signed [15:0] vx, input logic signed [15:0] vy,
                               input logic lst);
    if (traffic != TRAFFIC_STEADY && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 150)) @(posedge clk);
    end
    in_valid <= 1'b1;
    vel_x    <= vx;
    vel_y    <= vy;
    last     <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    transfers_sent++;
  endtask

  function automatic logic signed [15:0] corner_value();
    case ($urandom_range(4))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return 16'sd0;
      3:       return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  initial begin : stimulus
    int                 n;
    int                 sent;
    int                 set_size;
    int                 pick;
    int                 base_x;
    int                 base_y;
    logic               aligned;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    vel_x    <= '0;
    vel_y    <= '0;
    last     <= 1'b0;
    traffic  <= TRAFFIC_STEADY;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed sets: single unit vector, lone zero velocity, field extremes
    send_velocity(16'sd1, 16'sd0, 1'b1);
    send_velocity(16'sd0, 16'sd0, 1'b1);
    send_velocity(16'sd32767, 16'sd32767, 1'b0);
    send_velocity(-16'sd32768, -16'sd32768, 1'b1);
    send_velocity(-16'sd32768, 16'sd0, 1'b0);
    send_velocity(16'sd0, -16'sd32768, 1'b0);
    send_velocity(16'sd32767, -16'sd32768, 1'b1);
    send_velocity(16'sd0, 16'sd0, 1'b0);
    send_velocity(16'sd0, 16'sd1, 1'b0);
    send_velocity(-16'sd1, 16'sd0, 1'b1);
    send_velocity(16'sd0, -16'sd1, 1'b1);
    send_velocity(-16'sd32768, 16'sd32767, 1'b1);
    send_velocity(16'sd3, 16'sd4, 1'b0);
    send_velocity(16'sd3, 16'sd4, 1'b0);
    send_velocity(16'sd3, 16'sd4, 1'b0);
    send_velocity(-16'sd3, -16'sd4, 1'b1);
    send_velocity(16'sd1, -16'sd1, 1'b0);
    send_velocity(-16'sd32768, 16'sd1, 1'b1);

    // fill a set to the particle limit, then offer extra particles that must be dropped
    for (n = 0; n < MaxParticles - 2; n++) send_velocity(16'sd0, 16'sd0, 1'b0);
    send_velocity(16'sd3, 16'sd4, 1'b0);
    send_velocity(-16'sd5, 16'sd12, 1'b0);
    repeat (3) send_velocity(16'($urandom), 16'($urandom), 1'b0);
    send_velocity(16'($urandom), 16'($urandom), 1'b1);

    sent = 0;
    while (sent < RandomItems) begin
      if (sent >= 300 && sent < 450) traffic <= TRAFFIC_STEADY;
      else if (sent >= 600 && sent < 640) traffic <= TRAFFIC_BACKLOG;
      else traffic <= TRAFFIC_RANDOM;
      if (sent >= 600 && sent < 640) set_size = $urandom_range(1, 4);
      else if ($urandom_range(99) < 90) set_size = $urandom_range(1, 12);
      else set_size = $urandom_range(13, 40);
      // aligned sets give a high order parameter, mixed ones a low one
      aligned = ($urandom_range(99) < 40);
      base_x  = int'($urandom_range(40000)) - 20000;
      base_y  = int'($urandom_range(40000)) - 20000;
      for (n = 0; n < set_size; n++) begin
        pick = $urandom_range(99);
        if (pick < 5) begin
          vx = '0;
          vy = '0;
        end else if (pick < 15) begin
          vx = corner_value();
          vy = corner_value();
        end else if (pick < 30) begin
          vx = 16'(int'($urandom_range(8)) - 4);
          vy = 16'(int'($urandom_range(8)) - 4);
        end else if (aligned) begin
          vx = 16'(base_x + int'($urandom_range(4000)) - 2000);
          vy = 16'(base_y + int'($urandom_range(4000)) - 2000);
        end else begin
          vx = 16'($urandom);
          vy = 16'($urandom);
        end
        send_velocity(vx, vy, n == set_size - 1);
        sent++;
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (sets_due != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d velocity transfers and %0d checked sets, with field extremes,",
             transfers_sent, sets_checked);
    $display("zero velocities, a set past %0d particles and a %0d-cycle result hold",
             MaxParticles, HoldCycles);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
